@@ sv/tlbc_pkg.sv @@
// Shared types and constants for the tri LED blink controller.
`default_nettype none
package tlbc_pkg;

	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [MS_W-1:0] DEFAULT_MS = 16'd500;
	localparam logic [3:0]      PIN_MAX    = 4'd15;

	// Item opcodes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_BRIGHT = 2'd1;
	localparam logic [1:0] OP_BLINK  = 2'd2;

	// Channel codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_AMBER = 2'd2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_RED_ON    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RED_OFF   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_ON  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_OFF = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AMBER_ON  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_AMBER_OFF = 3'd5;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] channel;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [3:0] red_pin;
		logic [3:0] green_pin;
	} out_item_t;

	// Blink durations, indexed by channel code
	typedef struct packed {
		logic [NUM_CH-1:0][MS_W-1:0] on_ms;
		logic [NUM_CH-1:0][MS_W-1:0] off_ms;
	} blink_times_t;

endpackage
`default_nettype wire

@@ sv/tlbc_cfg_regs.sv @@
// Configuration register file holding the on and off times of each channel.
`default_nettype none
module tlbc_cfg_regs
	import tlbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [MS_W-1:0]      cfg_data,
	output blink_times_t              times
);

	blink_times_t times_q;

	assign cfg_ready = 1'b1;
	assign times     = times_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				times_q.on_ms[i]  <= DEFAULT_MS;
				times_q.off_ms[i] <= DEFAULT_MS;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RED_ON:    times_q.on_ms[CH_RED]    <= cfg_data;
				REG_RED_OFF:   times_q.off_ms[CH_RED]   <= cfg_data;
				REG_GREEN_ON:  times_q.on_ms[CH_GREEN]  <= cfg_data;
				REG_GREEN_OFF: times_q.off_ms[CH_GREEN] <= cfg_data;
				REG_AMBER_ON:  times_q.on_ms[CH_AMBER]  <= cfg_data;
				REG_AMBER_OFF: times_q.off_ms[CH_AMBER] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/tlbc_engine.sv @@
// Channel state and the combinational update for one tick or write item.
`default_nettype none
module tlbc_engine
	import tlbc_pkg::*;
#(
	parameter int unsigned LEVEL_DIVISOR_SHIFT = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire in_item_t     item,
	input  wire blink_times_t times,
	output out_item_t         pins_next
);

	typedef struct packed {
		logic [3:0]        red;
		logic [3:0]        green;
		logic [NUM_CH-1:0] lit;
	} pin_state_t;

	function automatic logic [3:0] scale(input logic [7:0] b);
		logic [7:0] sh;
		sh = b >> LEVEL_DIVISOR_SHIFT;
		return (sh > {4'd0, PIN_MAX}) ? PIN_MAX : sh[3:0];
	endfunction

	function automatic pin_state_t act_on(input pin_state_t p, input logic [1:0] c,
			input logic [3:0] v);
		pin_state_t r;
		r = p;
		if (c == CH_RED) begin
			r.red = v;
		end else if (c == CH_GREEN) begin
			r.green = v;
		end else begin
			r.red   = v;
			r.green = v;
		end
		r.lit[c] = 1'b1;
		return r;
	endfunction

	// A pin stays lit while another channel driving it is still on
	function automatic pin_state_t act_off(input pin_state_t p, input logic [1:0] c);
		pin_state_t r;
		r = p;
		if (c == CH_RED) begin
			if (!p.lit[CH_AMBER]) r.red = 4'd0;
		end else if (c == CH_GREEN) begin
			if (!p.lit[CH_AMBER]) r.green = 4'd0;
		end else begin
			if (!p.lit[CH_RED])   r.red   = 4'd0;
			if (!p.lit[CH_GREEN]) r.green = 4'd0;
		end
		r.lit[c] = 1'b0;
		return r;
	endfunction

	logic [NUM_CH-1:0][7:0]      bright_q, bright_d;
	logic [NUM_CH-1:0]           blink_q, blink_d;
	logic [NUM_CH-1:0]           phase_q, phase_d;
	logic [NUM_CH-1:0]           armed_q, armed_d;
	logic [NUM_CH-1:0][MS_W-1:0] rem_q, rem_d;
	pin_state_t                  pins_q, pins_d;

	always_comb begin
		logic [1:0] c;
		bright_d = bright_q;
		blink_d  = blink_q;
		phase_d  = phase_q;
		armed_d  = armed_q;
		rem_d    = rem_q;
		pins_d   = pins_q;
		case (item.op)
			OP_TICK: begin
				// red, green, amber in turn: amber sees the others' new lit flags
				for (c = 2'd0; c < 2'd3; c++) begin
					if (armed_d[c]) begin
						if (rem_d[c] <= 16'd1) begin
							if (blink_d[c] && phase_d[c]) begin
								pins_d     = act_off(pins_d, c);
								phase_d[c] = 1'b0;
								rem_d[c]   = times.off_ms[c];
							end else begin
								pins_d = act_on(pins_d, c, scale(bright_d[c]));
								if (blink_d[c]) begin
									phase_d[c] = 1'b1;
									rem_d[c]   = times.on_ms[c];
								end else begin
									armed_d[c] = 1'b0;
								end
							end
						end else begin
							rem_d[c] = rem_d[c] - 16'd1;
						end
					end
				end
			end
			OP_BRIGHT: begin
				if (item.channel <= CH_AMBER) begin
					bright_d[item.channel] = item.level;
					if (item.channel == CH_RED) begin
						pins_d.red = scale(item.level);
					end else if (item.channel == CH_GREEN) begin
						pins_d.green = scale(item.level);
					end else begin
						pins_d.red   = scale(item.level);
						pins_d.green = scale(item.level);
					end
				end
			end
			OP_BLINK: begin
				if (item.channel <= CH_AMBER) begin
					if (item.level == 8'd0) begin
						blink_d[item.channel] = 1'b0;
					end else begin
						blink_d[item.channel] = 1'b1;
						phase_d[item.channel] = 1'b0;
						pins_d                = act_off(pins_d, item.channel);
						armed_d[item.channel] = 1'b1;
						rem_d[item.channel]   = times.off_ms[item.channel];
					end
				end
			end
			default: ;
		endcase
	end

	assign pins_next.red_pin   = pins_d.red;
	assign pins_next.green_pin = pins_d.green;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
			blink_q  <= '0;
			phase_q  <= '0;
			armed_q  <= '0;
			rem_q    <= '0;
			pins_q   <= '0;
		end else if (step) begin
			bright_q <= bright_d;
			blink_q  <= blink_d;
			phase_q  <= phase_d;
			armed_q  <= armed_d;
			rem_q    <= rem_d;
			pins_q   <= pins_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/tri_led_blink_controller.sv @@
// Top level of the tri LED blink controller: input register, engine, result register.
// Drives a red and a green LED pin for three channels (red, green, and amber,
// which lights both pins). Each input transfer is a one-millisecond tick
// (op 0), a brightness write (op 1) or a blink enable write (op 2); every
// input transfer yields exactly one output transfer with the two pin
// intensities as they stand after that item. Pin intensity is the channel's
// brightness shifted right by LEVEL_DIVISOR_SHIFT, saturated at 15. Flow:
// an item is held in the input register, processed combinationally by the
// engine and lands in the result register; throughput is one item per cycle
// while the output is not stalled, the only limit being the engine's single
// state update per clock, made when the result register is free or being
// drained. The on and off times sit on a separate configuration port
// (index 0..5: red on/off, green on/off, amber on/off, reset 500 ticks) which
// is always ready; write it only while no items are in flight. Indexes above
// 5 are dropped.
`default_nettype none
module tri_led_blink_controller
	import tlbc_pkg::*;
#(
	parameter int unsigned LEVEL_DIVISOR_SHIFT = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [MS_W-1:0]      cfg_data
);

	blink_times_t times;
	in_item_t     item_s1;
	logic         valid_s1;
	out_item_t    pins_next;
	out_item_t    out_q;
	logic         out_valid_q;
	logic         advance;

	tlbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.times     (times)
	);

	// Item in stage 1 moves on when the result register has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	tlbc_engine #(
		.LEVEL_DIVISOR_SHIFT (LEVEL_DIVISOR_SHIFT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.times     (times),
		.pins_next (pins_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= pins_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire
